// ----- design/ugns_pkg.sv -----
`default_nettype none
package ugns_pkg;

  // Sizes of the particle store and the grid
  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned MAX_CELLS     = 4096;
  localparam int unsigned CELL_CAPACITY = 4;

  localparam int unsigned PART_W  = $clog2(MAX_PARTICLES);
  localparam int unsigned TOTAL_W = PART_W + 1;
  localparam int unsigned CELL_W  = $clog2(MAX_CELLS);
  localparam int unsigned SLOT_W  = $clog2(MAX_CELLS * CELL_CAPACITY);
  localparam int unsigned FILL_W  = 3;
  localparam int unsigned CRD_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_OUTSIDE    = 3'd1;
  localparam logic [ST_W-1:0] ST_CELL_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_STORE_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN    = 3'd4;

  // Register indexes
  localparam logic [CFG_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_W-1:0] CFG_INV_X    = 3'd2;
  localparam logic [CFG_W-1:0] CFG_INV_Y    = 3'd3;
  localparam logic [CFG_W-1:0] CFG_COUNT_X  = 3'd4;
  localparam logic [CFG_W-1:0] CFG_COUNT_Y  = 3'd5;

  typedef struct packed {
    logic [31:0]      origin_x;
    logic [31:0]      origin_y;
    logic [31:0]      inv_x;
    logic [31:0]      inv_y;
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
  } grid_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              outside;
    logic [CRD_W-1:0]  cx;
    logic [CRD_W-1:0]  cy;
    logic [CELL_W-1:0] cell_idx;
    logic [ID_W-1:0]   pid;
  } item_t;

  // Clamp a cell count register to 1..64
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == CNT_W'(0)) r = CNT_W'(1);
    else if (v > CNT_W'(64)) r = CNT_W'(64);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/uniform_grid_neighbor_search_top.sv -----
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o  | operation_i pos_x_i pos_y_i particle_id_i
// out     | output    | out_valid_o/out_stall_i| neighbor_id_o status_o last_o
// cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// An insert passes three front stages with a 32x32 multiplier per axis, then a fill read
// and a write in the back end. A query reads the particle's stored cell coordinates, then
// walks the 3x3 neighbor cells, skipping any out of range, and reads the fill count and
// then each entry of every in-range cell; each memory read is registered. A clear sweeps
// all 4096 cell counts, one a cycle; after reset the same sweep runs with in_stall_o high.
// Output stalls hold the back end; the front-to-back queue keeps the front going till full.
module uniform_grid_neighbor_search_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [9:0]  particle_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       neighbor_id_o,
  output logic [2:0]       status_o,
  output logic             last_o
);
  import ugns_pkg::*;

  logic [31:0]      origin_x_q, origin_y_q, inv_x_q, inv_y_q;
  logic [CNT_W-1:0] count_x_q, count_y_q;
  grid_t            grid;
  logic             init_busy, push, full, pop, empty;
  item_t            front_item, head_item;

  assign cfg_ready_o = 1'b1;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_x_q    <= 32'd65536;
      inv_y_q    <= 32'd65536;
      count_x_q  <= CNT_W'(64);
      count_y_q  <= CNT_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_INV_X:    inv_x_q    <= cfg_data_i;
        CFG_INV_Y:    inv_y_q    <= cfg_data_i;
        CFG_COUNT_X:  count_x_q  <= cfg_data_i[CNT_W-1:0];
        CFG_COUNT_Y:  count_y_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    grid.origin_x = origin_x_q;
    grid.origin_y = origin_y_q;
    grid.inv_x    = inv_x_q;
    grid.inv_y    = inv_y_q;
    grid.nx       = eff_count(count_x_q);
    grid.ny       = eff_count(count_y_q);
  end

  ugns_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_i        (grid),
    .hold_i        (init_busy),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .particle_id_i (particle_id_i),
    .push_o        (push),
    .item_o        (front_item),
    .full_i        (full)
  );

  ugns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  ugns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_i        (grid),
    .item_i        (head_item),
    .empty_i       (empty),
    .pop_o         (pop),
    .init_busy_o   (init_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .neighbor_id_o (neighbor_id_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ----- design/ugns_front.sv -----
`default_nettype none
module ugns_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  ugns_pkg::grid_t      grid_i,
  input  wire logic            hold_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [1:0]      operation_i,
  input  wire logic [31:0]     pos_x_i,
  input  wire logic [31:0]     pos_y_i,
  input  wire logic [9:0]      particle_id_i,
  output logic                 push_o,
  output ugns_pkg::item_t      item_o,
  input  wire logic            full_i
);
  import ugns_pkg::*;

  localparam logic [1:0] PH_MUL  = 2'd0;
  localparam logic [1:0] PH_CLS  = 2'd1;
  localparam logic [1:0] PH_PUSH = 2'd2;

  logic        busy_q, busy_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  op_q;
  logic [ID_W-1:0] pid_q;
  logic [32:0] dx_q, dy_q;
  logic [31:0] qx_q, qy_q;
  logic        negx_q, negy_q;
  item_t       item_q;

  logic        accept;
  logic [63:0] prodx, prody;
  logic        xok, yok;
  logic [CRD_W-1:0] cx, cy;
  logic [IDX_W-1:0] cellw;

  assign in_stall_o = busy_q || hold_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = busy_q && (phase_q == PH_PUSH) && !full_i;
  assign item_o     = item_q;

  // Scale offsets by the reciprocal cell size
  assign prodx = 64'(dx_q[31:0]) * 64'(grid_i.inv_x);
  assign prody = 64'(dy_q[31:0]) * 64'(grid_i.inv_y);

  // Classify the cell coordinates
  always_comb begin
    xok   = negx_q ? (grid_i.inv_x == 32'd0) : (qx_q < 32'(grid_i.nx));
    yok   = negy_q ? (grid_i.inv_y == 32'd0) : (qy_q < 32'(grid_i.ny));
    cx    = negx_q ? '0 : qx_q[CRD_W-1:0];
    cy    = negy_q ? '0 : qy_q[CRD_W-1:0];
    cellw = IDX_W'(cx) * IDX_W'(grid_i.ny) + IDX_W'(cy);
  end

  // Advance the phase sequence
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    if (!busy_q) begin
      if (accept) begin
        busy_d  = 1'b1;
        phase_d = PH_MUL;
      end
    end else begin
      unique case (phase_q)
        PH_MUL:  phase_d = PH_CLS;
        PH_CLS:  phase_d = PH_PUSH;
        PH_PUSH: begin
          if (!full_i) begin
            busy_d  = 1'b0;
            phase_d = PH_MUL;
          end
        end
        default: phase_d = PH_MUL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_MUL;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  // Hold the item payload through the phases
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      pid_q <= particle_id_i;
      dx_q  <= {pos_x_i[31], pos_x_i} - {grid_i.origin_x[31], grid_i.origin_x};
      dy_q  <= {pos_y_i[31], pos_y_i} - {grid_i.origin_y[31], grid_i.origin_y};
    end
    if (busy_q && phase_q == PH_MUL) begin
      qx_q   <= prodx[63:32];
      qy_q   <= prody[63:32];
      negx_q <= dx_q[32];
      negy_q <= dy_q[32];
    end
    if (busy_q && phase_q == PH_CLS) begin
      item_q.op       <= op_q;
      item_q.outside  <= !xok || !yok || (cellw >= IDX_W'(MAX_CELLS));
      item_q.cx       <= cx;
      item_q.cy       <= cy;
      item_q.cell_idx <= cellw[CELL_W-1:0];
      item_q.pid      <= pid_q;
    end
  end

endmodule
`default_nettype wire

// ----- design/ugns_queue.sv -----
`default_nettype none
module ugns_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  ugns_pkg::item_t  item_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output ugns_pkg::item_t  item_o,
  output logic             empty_o
);
  import ugns_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned NUM_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [NUM_W-1:0] num_q;

  assign full_o  = (num_q == NUM_W'(QUEUE_DEPTH));
  assign empty_o = (num_q == '0);
  assign item_o  = slots_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) num_q <= num_q + NUM_W'(1);
      else if (pop_i && !push_i) num_q <= num_q - NUM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= item_i;
  end

endmodule
`default_nettype wire

// ----- design/ugns_back.sv -----
`default_nettype none
module ugns_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  ugns_pkg::grid_t  grid_i,
  input  ugns_pkg::item_t  item_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             init_busy_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [9:0]       neighbor_id_o,
  output logic [2:0]       status_o,
  output logic             last_o
);
  import ugns_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_CLR     = 4'd2;
  localparam logic [3:0] S_INS_RD  = 4'd3;
  localparam logic [3:0] S_INS_CHK = 4'd4;
  localparam logic [3:0] S_Q_ISS   = 4'd5;
  localparam logic [3:0] S_Q_CELL  = 4'd6;
  localparam logic [3:0] S_Q_FILL  = 4'd7;
  localparam logic [3:0] S_Q_SLOT  = 4'd8;
  localparam logic [3:0] S_Q_SDAT  = 4'd9;
  localparam logic [3:0] S_Q_END   = 4'd10;
  localparam logic [3:0] S_RES     = 4'd11;

  // Memories
  logic [FILL_W-1:0]  fill_mem [MAX_CELLS];
  logic [2*CRD_W-1:0] crd_mem  [MAX_PARTICLES];
  logic [ID_W-1:0]    slot_mem [MAX_CELLS * CELL_CAPACITY];
  logic [FILL_W-1:0]  fill_rd_q;
  logic [2*CRD_W-1:0] crd_rd_q;
  logic [ID_W-1:0]    slot_rd_q;

  logic [3:0]         state_q, state_d;
  logic [CELL_W-1:0]  ctr_q, ctr_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic [CRD_W-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [ID_W-1:0]    pid_q, pid_d;
  logic [ID_W-1:0]    res_id_q, res_id_d;
  logic [ST_W-1:0]    res_st_q, res_st_d;
  logic [1:0]         ox_q, ox_d, oy_q, oy_d;
  logic [FILL_W-1:0]  s_q, s_d, fill_q, fill_d;
  logic               pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]    pend_id_q, pend_id_d;
  logic               out_valid_q;
  logic [ID_W-1:0]    out_id_q;
  logic [ST_W-1:0]    out_st_q;
  logic               out_last_q;

  logic               ld_out, ld_last;
  logic [ID_W-1:0]    ld_id;
  logic [ST_W-1:0]    ld_st;
  logic               out_free;

  logic               fill_we, slot_we, crd_we;
  logic [CELL_W-1:0]  fill_waddr, fill_raddr;
  logic [FILL_W-1:0]  fill_wdata;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
  logic [PART_W-1:0]  crd_waddr;

  logic [7:0]         tx, ty;
  logic [CNT_W-1:0]   qx, qy;
  logic [IDX_W-1:0]   ncell;
  logic               nb_ok, nb_last;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign neighbor_id_o = out_id_q;
  assign status_o      = out_st_q;
  assign last_o        = out_last_q;
  assign init_busy_o   = (state_q == S_INIT);

  // Neighbor cell around the queried particle
  always_comb begin
    tx      = {2'b00, crd_rd_q[2*CRD_W-1:CRD_W]} + {6'b0, ox_q};
    ty      = {2'b00, crd_rd_q[CRD_W-1:0]} + {6'b0, oy_q};
    qx      = CNT_W'(tx - 8'd1);
    qy      = CNT_W'(ty - 8'd1);
    ncell   = IDX_W'(qx) * IDX_W'(grid_i.ny) + IDX_W'(qy);
    nb_ok   = (tx != 8'd0) && (ty != 8'd0) && (qx < grid_i.nx) && (qy < grid_i.ny)
              && (ncell < IDX_W'(MAX_CELLS));
    nb_last = (ox_q == 2'd2) && (oy_q == 2'd2);
  end

  assign fill_raddr = (state_q == S_Q_CELL) ? ncell[CELL_W-1:0] : cell_q;
  assign slot_raddr = SLOT_W'(cell_q) * SLOT_W'(CELL_CAPACITY) + SLOT_W'(s_q);
  assign slot_waddr = SLOT_W'(cell_q) * SLOT_W'(CELL_CAPACITY) + SLOT_W'(fill_rd_q);
  assign crd_waddr  = total_q[PART_W-1:0];

  // Sequence the operations
  always_comb begin
    state_d      = state_q;
    ctr_d        = ctr_q;
    total_d      = total_q;
    cell_d       = cell_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    pid_d        = pid_q;
    res_id_d     = res_id_q;
    res_st_d     = res_st_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    s_d          = s_q;
    fill_d       = fill_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pop_o        = 1'b0;
    ld_out       = 1'b0;
    ld_id        = '0;
    ld_st        = ST_OK;
    ld_last      = 1'b0;
    fill_we      = 1'b0;
    fill_waddr   = ctr_q;
    fill_wdata   = '0;
    slot_we      = 1'b0;
    crd_we       = 1'b0;

    unique case (state_q)
      S_INIT, S_CLR: begin
        fill_we = 1'b1;
        ctr_d   = ctr_q + CELL_W'(1);
        if (ctr_q == CELL_W'(MAX_CELLS - 1)) begin
          ctr_d    = '0;
          res_id_d = '0;
          res_st_d = ST_OK;
          state_d  = (state_q == S_CLR) ? S_RES : S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          cell_d   = item_i.cell_idx;
          cx_d     = item_i.cx;
          cy_d     = item_i.cy;
          pid_d    = item_i.pid;
          res_id_d = '0;
          case (item_i.op)
            OP_CLEAR: begin
              ctr_d   = '0;
              state_d = S_CLR;
            end
            OP_INSERT: begin
              if (item_i.outside) begin
                res_st_d = ST_OUTSIDE;
                state_d  = S_RES;
              end else if (total_q >= TOTAL_W'(MAX_PARTICLES)) begin
                res_st_d = ST_STORE_FULL;
                state_d  = S_RES;
              end else begin
                state_d = S_INS_RD;
              end
            end
            OP_QUERY: begin
              if (TOTAL_W'(item_i.pid) >= total_q) begin
                res_st_d = ST_UNKNOWN;
                state_d  = S_RES;
              end else begin
                ox_d         = '0;
                oy_d         = '0;
                pend_valid_d = 1'b0;
                state_d      = S_Q_ISS;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INS_RD: state_d = S_INS_CHK;
      S_INS_CHK: begin
        if (fill_rd_q >= FILL_W'(CELL_CAPACITY)) begin
          res_st_d = ST_CELL_FULL;
        end else begin
          fill_we    = 1'b1;
          fill_waddr = cell_q;
          fill_wdata = fill_rd_q + FILL_W'(1);
          slot_we    = 1'b1;
          crd_we     = 1'b1;
          res_id_d   = total_q[ID_W-1:0];
          res_st_d   = ST_OK;
          total_d    = total_q + TOTAL_W'(1);
        end
        state_d = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          ld_out  = 1'b1;
          ld_id   = res_id_q;
          ld_st   = res_st_q;
          ld_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_Q_ISS: state_d = S_Q_CELL;
      S_Q_CELL: begin
        if (nb_ok) begin
          cell_d  = ncell[CELL_W-1:0];
          state_d = S_Q_FILL;
        end else if (nb_last) begin
          state_d = S_Q_END;
        end else begin
          if (oy_q == 2'd2) begin
            oy_d = '0;
            ox_d = ox_q + 2'd1;
          end else begin
            oy_d = oy_q + 2'd1;
          end
        end
      end
      S_Q_FILL: begin
        fill_d  = (fill_rd_q > FILL_W'(CELL_CAPACITY)) ? FILL_W'(CELL_CAPACITY) : fill_rd_q;
        s_d     = '0;
        state_d = S_Q_SLOT;
      end
      S_Q_SLOT: begin
        if (s_q < fill_q) begin
          state_d = S_Q_SDAT;
        end else if (nb_last) begin
          state_d = S_Q_END;
        end else begin
          state_d = S_Q_CELL;
          if (oy_q == 2'd2) begin
            oy_d = '0;
            ox_d = ox_q + 2'd1;
          end else begin
            oy_d = oy_q + 2'd1;
          end
        end
      end
      S_Q_SDAT: begin
        // Release the held beat once the next one is known
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            ld_out = 1'b1;
            ld_id  = pend_id_q;
          end
          pend_id_d    = slot_rd_q;
          pend_valid_d = 1'b1;
          s_d          = s_q + FILL_W'(1);
          state_d      = S_Q_SLOT;
        end
      end
      S_Q_END: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          ld_out       = 1'b1;
          ld_id        = pend_id_q;
          ld_last      = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      ctr_q        <= '0;
      total_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ox_q         <= '0;
      oy_q         <= '0;
      s_q          <= '0;
    end else begin
      state_q      <= state_d;
      ctr_q        <= ctr_d;
      total_q      <= total_d;
      pend_valid_q <= pend_valid_d;
      ox_q         <= ox_d;
      oy_q         <= oy_d;
      s_q          <= s_d;
      if (ld_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    cell_q    <= cell_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    pid_q     <= pid_d;
    res_id_q  <= res_id_d;
    res_st_q  <= res_st_d;
    fill_q    <= fill_d;
    pend_id_q <= pend_id_d;
    if (ld_out) begin
      out_id_q   <= ld_id;
      out_st_q   <= ld_st;
      out_last_q <= ld_last;
    end
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd_q <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= total_q[ID_W-1:0];
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (crd_we) crd_mem[crd_waddr] <= {cx_q, cy_q};
    crd_rd_q <= crd_mem[pid_q[PART_W-1:0]];
  end

endmodule
`default_nettype wire
